// ----- sv/bba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

   localparam int MAX_LEVEL       = 10;
   localparam int TOP_BLOCK_COUNT = 32;
   localparam int MIN_BLOCK_SHIFT = 7;
   localparam int MIN_BLOCK_BYTES = 1 << MIN_BLOCK_SHIFT;
   localparam int HEADER_BYTES    = 40;

   localparam int REQ_W       = 32;
   localparam int NEED_W      = REQ_W + 1;
   localparam int OFFSET_W    = 22;
   localparam int ORDER_OUT_W = 4;
   localparam int ORDER_W     = $clog2(MAX_LEVEL + 1);
   localparam int FREE_IDX_W  = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1;
   localparam int TAKEN_W     = $clog2(TOP_BLOCK_COUNT + 1);
   localparam int TOP_SHIFT   = MIN_BLOCK_SHIFT + MAX_LEVEL;

   typedef enum logic [1:0] {
      STATUS_GRANTED   = 2'd0,
      STATUS_NO_MEMORY = 2'd1,
      STATUS_OVERSIZE  = 2'd2
   } status_type;

   // Operation select for the shared order unit
   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic               use_header;
   } unit_op_type;

   typedef struct packed {
      logic                fits;
      logic [OFFSET_W-1:0] sum;
   } unit_res_type;

endpackage : bba_pkg
`default_nettype wire

// ----- sv/bba_order_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bba_order_unit (
   input  wire bba_pkg::unit_op_type             op,
   input  wire logic [bba_pkg::NEED_W-1:0]       need,
   input  wire logic [bba_pkg::OFFSET_W-1:0]     base,
   output bba_pkg::unit_res_type                 res
);
   import bba_pkg::*;

   logic [NEED_W-1:0]   block_bytes;
   logic [OFFSET_W-1:0] addend;

   // Block size of the selected order, then fit test and offset add
   assign block_bytes = NEED_W'(MIN_BLOCK_BYTES) << op.order;
   assign addend      = op.use_header ? OFFSET_W'(HEADER_BYTES) : block_bytes[OFFSET_W-1:0];
   assign res.fits    = (block_bytes >= need);
   assign res.sum     = base + addend;

endmodule : bba_order_unit
`default_nettype wire

// ----- sv/buddy_block_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------------
// request   | start, busy (start, !busy)| req_request_bytes
// result    | rsp_valid (one-cycle)     | rsp_status, rsp_payload_offset,
//           |                           | rsp_block_order
//
// One request at a time through a single shift/compare/add unit: the order
// search steps up from order 0 (to MAX_LEVEL when oversize), the free-list scan
// steps up from want, the split halves down to want; the result strobe follows.
// The longest request is an order 0 split from a fresh top block.
// Synchronous reset clears the free-list valid bits and the top-block count.
// The result is shown for one cycle as busy drops; the receiver cannot stall.
module buddy_block_allocator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [31:0]                         req_request_bytes,
   output logic                                     rsp_valid,
   output logic [1:0]                               rsp_status,
   output logic [21:0]                              rsp_payload_offset,
   output logic [3:0]                               rsp_block_order
);
   import bba_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SIZE   = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_SPLIT  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [ORDER_W-1:0]   k_ff, k_in;
   logic [ORDER_W-1:0]   want_ff, want_in;
   logic [ORDER_W-1:0]   src_ff, src_in;
   logic [NEED_W-1:0]    need_ff, need_in;
   logic [OFFSET_W-1:0]  base_ff, base_in;
   logic [TAKEN_W-1:0]   taken_ff, taken_in;
   logic                 free_valid_ff [MAX_LEVEL];
   logic                 free_valid_in [MAX_LEVEL];
   logic [OFFSET_W-1:0]  free_offset_ff [MAX_LEVEL];
   logic                 wr_en;
   logic [FREE_IDX_W-1:0] wr_idx;
   logic [OFFSET_W-1:0]  top_base;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [ORDER_W-1:0]   rsp_order_ff, rsp_order_in;

   unit_op_type          op;
   unit_res_type         res;

   bba_order_unit u_order_unit (
      .op   (op),
      .need (need_ff),
      .base (base_ff),
      .res  (res)
   );

   assign top_base = OFFSET_W'({taken_ff, {TOP_SHIFT{1'b0}}});

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      want_in       = want_ff;
      src_in        = src_ff;
      need_in       = need_ff;
      base_in       = base_ff;
      taken_in      = taken_ff;
      free_valid_in = free_valid_ff;
      wr_en         = 1'b0;
      wr_idx        = '0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_order_in  = rsp_order_ff;
      op.order      = k_ff;
      op.use_header = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               need_in  = NEED_W'(req_request_bytes) + NEED_W'(HEADER_BYTES);
               k_in     = '0;
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            if (res.fits) begin
               want_in  = k_ff;
               state_in = ST_SEARCH;
            end else if (k_ff == ORDER_W'(MAX_LEVEL)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OVERSIZE;
               rsp_offset_in = '0;
               rsp_order_in  = '0;
               state_in      = ST_IDLE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_SEARCH: begin
            if (k_ff == ORDER_W'(MAX_LEVEL)) begin
               if (taken_ff < TAKEN_W'(TOP_BLOCK_COUNT)) begin
                  base_in  = top_base;
                  taken_in = taken_ff + 1'b1;
                  src_in   = k_ff;
                  state_in = ST_SPLIT;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NO_MEMORY;
                  rsp_offset_in = '0;
                  rsp_order_in  = '0;
                  state_in      = ST_IDLE;
               end
            end else if (free_valid_ff[k_ff[FREE_IDX_W-1:0]]) begin
               base_in  = free_offset_ff[k_ff[FREE_IDX_W-1:0]];
               free_valid_in[k_ff[FREE_IDX_W-1:0]] = 1'b0;
               src_in   = k_ff;
               state_in = ST_SPLIT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_SPLIT: begin
            if (src_ff != want_ff) begin
               // Park the upper half on the free slot of the order below
               op.order = src_ff - 1'b1;
               wr_en    = 1'b1;
               wr_idx   = op.order[FREE_IDX_W-1:0];
               free_valid_in[wr_idx] = 1'b1;
               src_in   = op.order;
            end else begin
               op.use_header = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_GRANTED;
               rsp_offset_in = res.sum;
               rsp_order_in  = want_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         taken_ff      <= '0;
         free_valid_ff <= '{default: 1'b0};
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         taken_ff      <= taken_in;
         free_valid_ff <= free_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      want_ff       <= want_in;
      src_ff        <= src_in;
      need_ff       <= need_in;
      base_ff       <= base_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_order_ff  <= rsp_order_in;
      if (wr_en) begin
         free_offset_ff[wr_idx] <= res.sum;
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_offset_ff;
   assign rsp_block_order    = ORDER_OUT_W'(rsp_order_ff);

endmodule : buddy_block_allocator
`default_nettype wire

// ----- sv/bba_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bba_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [1:0]  rsp_status,
   input wire logic [21:0] rsp_payload_offset,
   input wire logic [3:0]  rsp_block_order
);
   import bba_pkg::*;

   // An accepted request always makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // Results come out as busy drops, never while a request is in flight
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("request finished without a result");

   // Refused requests report no offset and no order
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_GRANTED)
         |-> (rsp_payload_offset == '0) && (rsp_block_order == '0)
            && (rsp_status == STATUS_NO_MEMORY || rsp_status == STATUS_OVERSIZE))
      else $error("refused result carries payload or bad status");

endmodule : bba_checker

bind buddy_block_allocator bba_checker u_bba_checker (.*);
`default_nettype wire
